// ===== src/ehf_pkg.sv =====
// ----------------------------------------------------------------------------
// ehf_pkg
// Shared types and constants of the Ethernet/IPv4/L4 header filter.
// ----------------------------------------------------------------------------
package ehf_pkg;

    // Frame layout and protocol numbers
    localparam logic [15:0] C_ETYPE_IPV4 = 16'h0800;
    localparam logic [6:0]  C_ETH_HDR    = 7'd14;
    localparam logic [7:0]  C_PROTO_TCP  = 8'd6;
    localparam logic [7:0]  C_PROTO_UDP  = 8'd17;
    localparam logic [6:0]  C_POS_MAX    = 7'd127;

    // Byte positions of the fixed header fields
    localparam logic [6:0] C_POS_ETYPE_HI = 7'd12;
    localparam logic [6:0] C_POS_ETYPE_LO = 7'd13;
    localparam logic [6:0] C_POS_IHL      = 7'd14;
    localparam logic [6:0] C_POS_TLEN_HI  = 7'd16;
    localparam logic [6:0] C_POS_TLEN_LO  = 7'd17;
    localparam logic [6:0] C_POS_FRAG_HI  = 7'd20;
    localparam logic [6:0] C_POS_FRAG_LO  = 7'd21;
    localparam logic [6:0] C_POS_TTL      = 7'd22;
    localparam logic [6:0] C_POS_PROTO    = 7'd23;
    localparam logic [6:0] C_POS_SIP_LO   = 7'd26;
    localparam logic [6:0] C_POS_SIP_HI   = 7'd29;
    localparam logic [6:0] C_POS_DIP_LO   = 7'd30;
    localparam logic [6:0] C_POS_DIP_HI   = 7'd33;

    // Minimum frame lengths per stage
    localparam logic [7:0] C_LEN_ETH  = 8'd14;
    localparam logic [7:0] C_LEN_SIP  = 8'd30;
    localparam logic [7:0] C_LEN_DIP  = 8'd34;

    // Transport offsets relative to the transport header start
    localparam logic [6:0] C_OFS_SPORT_LO = 7'd1;
    localparam logic [6:0] C_OFS_DPORT_HI = 7'd2;
    localparam logic [6:0] C_OFS_DPORT_LO = 7'd3;
    localparam logic [6:0] C_OFS_DET_HI   = 7'd4;
    localparam logic [6:0] C_OFS_DET_LO   = 7'd5;
    localparam logic [6:0] C_OFS_TCP_FLG  = 7'd13;
    localparam logic [7:0] C_NEED_SPORT   = 8'd2;
    localparam logic [7:0] C_NEED_DPORT   = 8'd4;
    localparam logic [7:0] C_NEED_UDP     = 8'd6;
    localparam logic [7:0] C_NEED_TCP     = 8'd14;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_IP   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT = 8'd3;

    typedef enum logic [3:0] {
        V_TCP_OK    = 4'd0,
        V_UDP_OK    = 4'd1,
        V_NOT_IPV4  = 4'd2,
        V_SRC_IP    = 4'd3,
        V_DST_IP    = 4'd4,
        V_FRAGMENT  = 4'd5,
        V_OTHER     = 4'd6,
        V_SPORT     = 4'd7,
        V_DPORT     = 4'd8,
        V_TRUNCATED = 4'd9
    } t_verdict;

    // Header fields captured so far in the current frame
    typedef struct packed {
        logic [15:0] ether_type;
        logic [3:0]  ihl;
        logic [15:0] total_length;
        logic [12:0] fragment;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] detail;
        logic [1:0]  tcp_flags;
    } t_hdr;

    // Filter match values; zero disables a check
    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_match;

    // One result item
    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] ether_type;
        logic [5:0]  ip_header_bytes;
        logic [15:0] ip_total_length;
        logic [15:0] fragment_offset_bytes;
        logic [7:0]  time_to_live;
        logic [7:0]  transport_protocol;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] transport_detail;
    } t_result;

endpackage

// ===== src/ehf_judge.sv =====
// ----------------------------------------------------------------------------
// ehf_judge
// Verdict logic: runs the ordered filter checks on the captured header and
// reports only the fields that the checks reached.
// ----------------------------------------------------------------------------
module ehf_judge
    import ehf_pkg::*;
(
    input  t_hdr       i_hdr,
    input  logic [7:0] i_len,
    input  t_match     i_match,
    output t_result    o_result
);

    logic [7:0] w_tstart;
    logic       w_is_tcp;
    logic       w_is_udp;

    // Transport header start, 14 plus four times IHL
    assign w_tstart = {1'b0, C_ETH_HDR} + {2'b00, i_hdr.ihl, 2'b00};
    assign w_is_tcp = (i_hdr.protocol == C_PROTO_TCP);
    assign w_is_udp = (i_hdr.protocol == C_PROTO_UDP);

    // Walk the checks in order; fields not reached stay zero
    always_comb begin
        o_result = '0;
        if (i_len < C_LEN_ETH) begin
            o_result.verdict = V_TRUNCATED;
        end else begin
            o_result.ether_type = i_hdr.ether_type;
            if (i_hdr.ether_type != C_ETYPE_IPV4) begin
                o_result.verdict = V_NOT_IPV4;
            end else if (i_len < C_LEN_SIP) begin
                o_result.verdict = V_TRUNCATED;
            end else begin
                o_result.ip_header_bytes       = {i_hdr.ihl, 2'b00};
                o_result.ip_total_length       = i_hdr.total_length;
                o_result.fragment_offset_bytes = {i_hdr.fragment, 3'b000};
                o_result.time_to_live          = i_hdr.ttl;
                o_result.transport_protocol    = i_hdr.protocol;
                o_result.source_ip             = i_hdr.source_ip;
                if (i_match.source_ip != '0 && i_match.source_ip != i_hdr.source_ip) begin
                    o_result.verdict = V_SRC_IP;
                end else if (i_len < C_LEN_DIP) begin
                    o_result.verdict = V_TRUNCATED;
                end else begin
                    o_result.dest_ip = i_hdr.dest_ip;
                    if (i_match.dest_ip != '0 && i_match.dest_ip != i_hdr.dest_ip) begin
                        o_result.verdict = V_DST_IP;
                    end else if (i_hdr.fragment != '0) begin
                        o_result.verdict = V_FRAGMENT;
                    end else if (!w_is_tcp && !w_is_udp) begin
                        o_result.verdict = V_OTHER;
                    end else if (i_len < w_tstart + C_NEED_SPORT) begin
                        o_result.verdict = V_TRUNCATED;
                    end else begin
                        o_result.source_port = i_hdr.source_port;
                        if (i_match.source_port != '0 &&
                            i_match.source_port != i_hdr.source_port) begin
                            o_result.verdict = V_SPORT;
                        end else if (i_len < w_tstart + C_NEED_DPORT) begin
                            o_result.verdict = V_TRUNCATED;
                        end else begin
                            o_result.dest_port = i_hdr.dest_port;
                            if (i_match.dest_port != '0 &&
                                i_match.dest_port != i_hdr.dest_port) begin
                                o_result.verdict = V_DPORT;
                            end else if (w_is_tcp) begin
                                if (i_len < w_tstart + C_NEED_TCP) begin
                                    o_result.verdict = V_TRUNCATED;
                                end else begin
                                    o_result.transport_detail = {14'd0, i_hdr.tcp_flags};
                                    o_result.verdict          = V_TCP_OK;
                                end
                            end else if (i_len < w_tstart + C_NEED_UDP) begin
                                o_result.verdict = V_TRUNCATED;
                            end else begin
                                o_result.transport_detail = i_hdr.detail;
                                o_result.verdict          = V_UDP_OK;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== src/eth_ipv4_l4_header_filter_unit.sv =====
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_filter_unit
// Byte-stream Ethernet/IPv4/TCP-UDP header parser and filter.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock cycle, from the destination MAC onward, with
// the last byte marked. Header fields are captured by byte position as they
// go by; on the last byte the ordered checks (IPv4, source IP, destination IP,
// first fragment, TCP/UDP, source port, destination port) run in the same
// cycle and one result item is registered, valid on the next cycle. The
// frame state clears at once, so the first byte of the next frame may follow
// the last byte directly. The only stall is a last byte arriving while the
// previous result is still held in the output register. Match registers are
// written through the config channel, which is always ready; a value of zero
// disables that check.
module eth_ipv4_l4_header_filter_unit
    import ehf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // byte input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_frame_byte,
    input  logic                 i_last_byte,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [3:0]           o_verdict,
    output logic [15:0]          o_ether_type,
    output logic [5:0]           o_ip_header_bytes,
    output logic [15:0]          o_ip_total_length,
    output logic [15:0]          o_fragment_offset_bytes,
    output logic [7:0]           o_time_to_live,
    output logic [7:0]           o_transport_protocol,
    output logic [31:0]          o_source_ip,
    output logic [31:0]          o_dest_ip,
    output logic [15:0]          o_source_port,
    output logic [15:0]          o_dest_port,
    output logic [15:0]          o_transport_detail
);

    t_match     r_match;
    logic [6:0] r_pos;
    t_hdr       r_hdr;
    t_hdr       n_hdr;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic [6:0] w_tstart;
    logic       w_accept;
    logic       w_emit;
    logic [7:0] w_len;

    assign o_cfg_ready = 1'b1;

    // Store match values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_IP:   r_match.source_ip   <= i_cfg_data;
                CFG_DST_IP:   r_match.dest_ip     <= i_cfg_data;
                CFG_SRC_PORT: r_match.source_port <= i_cfg_data[15:0];
                CFG_DST_PORT: r_match.dest_port   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Hold a last byte only while the output register is still occupied
    assign o_in_ready = !r_out_valid || i_out_ready || !i_last_byte;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_emit     = w_accept && i_last_byte;
    assign w_len      = {1'b0, r_pos} + 8'd1;

    // Transport start uses the IHL of this byte when it is the IHL byte
    always_comb begin
        logic [3:0] ihl;
        ihl      = (r_pos == C_POS_IHL) ? i_frame_byte[3:0] : r_hdr.ihl;
        w_tstart = C_ETH_HDR + {1'b0, ihl, 2'b00};
    end

    // Capture this byte into the header fields by position
    always_comb begin
        n_hdr = r_hdr;
        case (r_pos)
            C_POS_ETYPE_HI: n_hdr.ether_type[15:8]   = i_frame_byte;
            C_POS_ETYPE_LO: n_hdr.ether_type[7:0]    = i_frame_byte;
            C_POS_IHL:      n_hdr.ihl                = i_frame_byte[3:0];
            C_POS_TLEN_HI:  n_hdr.total_length[15:8] = i_frame_byte;
            C_POS_TLEN_LO:  n_hdr.total_length[7:0]  = i_frame_byte;
            C_POS_FRAG_HI:  n_hdr.fragment[12:8]     = i_frame_byte[4:0];
            C_POS_FRAG_LO:  n_hdr.fragment[7:0]      = i_frame_byte;
            C_POS_TTL:      n_hdr.ttl                = i_frame_byte;
            C_POS_PROTO:    n_hdr.protocol           = i_frame_byte;
            default: ;
        endcase
        if (r_pos >= C_POS_SIP_LO && r_pos <= C_POS_SIP_HI) begin
            n_hdr.source_ip = {r_hdr.source_ip[23:0], i_frame_byte};
        end
        if (r_pos >= C_POS_DIP_LO && r_pos <= C_POS_DIP_HI) begin
            n_hdr.dest_ip = {r_hdr.dest_ip[23:0], i_frame_byte};
        end
        // transport bytes; a small IHL lets these overlap the IP header
        if (r_pos == w_tstart) begin
            n_hdr.source_port[15:8] = i_frame_byte;
        end
        if (r_pos == w_tstart + C_OFS_SPORT_LO) begin
            n_hdr.source_port[7:0] = i_frame_byte;
        end
        if (r_pos == w_tstart + C_OFS_DPORT_HI) begin
            n_hdr.dest_port[15:8] = i_frame_byte;
        end
        if (r_pos == w_tstart + C_OFS_DPORT_LO) begin
            n_hdr.dest_port[7:0] = i_frame_byte;
        end
        if (r_pos == w_tstart + C_OFS_DET_HI) begin
            n_hdr.detail[15:8] = i_frame_byte;
        end
        if (r_pos == w_tstart + C_OFS_DET_LO) begin
            n_hdr.detail[7:0] = i_frame_byte;
        end
        if (r_pos == w_tstart + C_OFS_TCP_FLG) begin
            n_hdr.tcp_flags = i_frame_byte[1:0];
        end
    end

    ehf_judge u_judge (
        .i_hdr    (n_hdr),
        .i_len    (w_len),
        .i_match  (r_match),
        .o_result (w_result)
    );

    // Advance the frame state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hdr <= '0;
        end else if (w_accept) begin
            if (i_last_byte) begin
                r_pos <= '0;
                r_hdr <= '0;
            end else begin
                r_hdr <= n_hdr;
                if (r_pos != C_POS_MAX) begin
                    r_pos <= r_pos + 7'd1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_verdict               = r_out.verdict;
    assign o_ether_type            = r_out.ether_type;
    assign o_ip_header_bytes       = r_out.ip_header_bytes;
    assign o_ip_total_length       = r_out.ip_total_length;
    assign o_fragment_offset_bytes = r_out.fragment_offset_bytes;
    assign o_time_to_live          = r_out.time_to_live;
    assign o_transport_protocol    = r_out.transport_protocol;
    assign o_source_ip             = r_out.source_ip;
    assign o_dest_ip               = r_out.dest_ip;
    assign o_source_port           = r_out.source_port;
    assign o_dest_port             = r_out.dest_port;
    assign o_transport_detail      = r_out.transport_detail;

endmodule
